### design/prlc_pkg.sv
// Package for the PIN retry lockout controller: sizes, command and register codes,
// payload structs and the control struct between controller and datapath.
// No dependencies.
package prlc_pkg;

    localparam int SCOPES     = 3;
    localparam int PIN_DIGITS = 4;
    localparam int SIDX_W     = (SCOPES > 1) ? $clog2(SCOPES) : 1;
    localparam int TIME_W     = 48;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [2:0] CMD_VERIFY      = 3'd0;
    localparam logic [2:0] CMD_QUERY_LOCK  = 3'd1;
    localparam logic [2:0] CMD_RESET_SCOPE = 3'd3;
    localparam logic [2:0] CMD_RESET_ALL   = 3'd4;

    localparam logic [1:0] REG_SECURITY     = 2'd0;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;
    localparam logic [1:0] REG_LOCKOUT      = 2'd2;

    localparam logic [0:0]  RST_SECURITY     = 1'b1;
    localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd5;
    localparam logic [31:0] RST_LOCKOUT      = 32'd30000;

    localparam logic [7:0] FAIL_MAX  = 8'hFF;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [1:0]        scope;
        logic [TIME_W-1:0] now_ms;
        logic [15:0]       pin_digits;
        logic              hash_match;
    } in_t;

    typedef struct packed {
        logic        granted;
        logic        locked;
        logic [31:0] remaining_ms;
        logic [7:0]  attempts_left;
        logic        rejected;
    } out_t;

    typedef struct packed {
        logic        security_enabled;
        logic [7:0]  max_attempts;
        logic [31:0] lockout_ms;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic publish;
    } ctrl_cmd_t;

endpackage

### design/prlc_regs.sv
// Configuration register bank behind the APB-style port.
// Depends on prlc_pkg.
module prlc_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prlc_pkg::PADDR_W-1:0]   paddr,
    input  logic [prlc_pkg::PDATA_W-1:0]   pwdata,
    output logic [prlc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output prlc_pkg::cfg_t                 cfg
);
    import prlc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SECURITY:     cfg_next.security_enabled = pwdata[0];
                REG_MAX_ATTEMPTS: cfg_next.max_attempts     = pwdata[7:0];
                REG_LOCKOUT:      cfg_next.lockout_ms       = pwdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.security_enabled <= RST_SECURITY[0];
            cfg_reg.max_attempts     <= RST_MAX_ATTEMPTS;
            cfg_reg.lockout_ms       <= RST_LOCKOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SECURITY:     prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.security_enabled};
            REG_MAX_ATTEMPTS: prdata = {{(PDATA_W-8){1'b0}}, cfg_reg.max_attempts};
            REG_LOCKOUT:      prdata = cfg_reg.lockout_ms;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/prlc_ctrl.sv
// Sequencing FSM: accept, execute, publish into the output register.
// Depends on prlc_pkg.
module prlc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output prlc_pkg::ctrl_cmd_t  ctl
);
    import prlc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_STAT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next  = state_reg;
        ctl.load    = 1'b0;
        ctl.exec    = 1'b0;
        ctl.publish = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_STAT;
            end
            ST_STAT: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.publish |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while still pending");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not executed");

    a_exec_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (state_reg == ST_STAT))
        else $error("execute not followed by status");

    a_rise_from_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_STAT))
        else $error("result raised outside status state");
`endif

endmodule

### design/prlc_dp.sv
// Datapath: input register, per-scope counter and deadline state, update and
// status logic, output register. Depends on prlc_pkg.
module prlc_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prlc_pkg::ctrl_cmd_t  ctl,
    input  prlc_pkg::cfg_t       cfg,
    input  prlc_pkg::in_t        s_data,
    output prlc_pkg::out_t       m_data
);
    import prlc_pkg::*;

    in_t               item_reg;
    logic [7:0]        fc_reg [SCOPES];
    logic [TIME_W-1:0] dl_reg [SCOPES];
    logic              granted_reg;
    logic              rejected_reg;
    logic              show_reg;
    out_t              result_reg;

    logic              scope_ok;
    logic [SIDX_W-1:0] sidx;
    logic              digits_ok;
    logic [7:0]        cur_fc;
    logic [TIME_W-1:0] cur_dl;
    logic              lock_now;
    logic              expired;
    logic [7:0]        base_fc;
    logic [7:0]        fc_inc;
    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] dl_arm;
    logic              is_op;
    logic              wr_en;
    logic              clr_all;
    logic [7:0]        wr_fc;
    logic [TIME_W-1:0] wr_dl;
    logic              granted_c;
    logic              rejected_c;

    logic [7:0]        st_fc;
    logic [TIME_W-1:0] st_dl;
    logic [TIME_W:0]   rem_diff;
    logic              st_gt;
    logic [31:0]       st_rem;
    logic [8:0]        att_diff;
    logic [7:0]        st_att;

    assign scope_ok = ({1'b0, item_reg.scope} < 3'(SCOPES));
    assign sidx     = scope_ok ? item_reg.scope[SIDX_W-1:0] : '0;
    assign is_op    = (item_reg.cmd <= CMD_RESET_ALL);

    always_comb begin
        digits_ok = 1'b1;
        for (int i = 0; i < PIN_DIGITS; i++) begin
            if (item_reg.pin_digits[4*i +: 4] > DIGIT_MAX) begin
                digits_ok = 1'b0;
            end
        end
    end

    // execute cycle
    assign cur_fc   = fc_reg[sidx];
    assign cur_dl   = dl_reg[sidx];
    assign lock_now = (cur_dl > item_reg.now_ms);
    assign expired  = !lock_now && (cur_dl != '0);
    assign base_fc  = expired ? 8'd0 : cur_fc;
    assign fc_inc   = base_fc + 8'd1;
    assign dl_sum   = {1'b0, item_reg.now_ms} + {{(TIME_W-31){1'b0}}, cfg.lockout_ms};
    assign dl_arm   = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    always_comb begin
        wr_en      = 1'b0;
        clr_all    = 1'b0;
        wr_fc      = cur_fc;
        wr_dl      = cur_dl;
        granted_c  = 1'b0;
        rejected_c = is_op && (item_reg.cmd != CMD_RESET_ALL) && !scope_ok;
        case (item_reg.cmd)
            CMD_VERIFY: begin
                if (!scope_ok || !digits_ok) begin
                    rejected_c = 1'b1;
                end else if (!cfg.security_enabled && (item_reg.scope == 2'd0)) begin
                    granted_c = 1'b1;
                end else if (!lock_now) begin
                    wr_en = 1'b1;
                    wr_dl = '0;
                    if (item_reg.hash_match) begin
                        wr_fc     = 8'd0;
                        granted_c = 1'b1;
                    end else if (base_fc != FAIL_MAX) begin
                        wr_fc = fc_inc;
                        if (fc_inc >= cfg.max_attempts) begin
                            wr_dl = dl_arm;
                        end
                    end else begin
                        wr_fc = base_fc;
                    end
                end
            end
            CMD_QUERY_LOCK: begin
                if (scope_ok && expired) begin
                    wr_en = 1'b1;
                    wr_fc = 8'd0;
                    wr_dl = '0;
                end
            end
            CMD_RESET_SCOPE: begin
                if (scope_ok) begin
                    wr_en = 1'b1;
                    wr_fc = 8'd0;
                    wr_dl = '0;
                end
            end
            CMD_RESET_ALL: begin
                clr_all = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SCOPES; i++) begin
                fc_reg[i] <= 8'd0;
                dl_reg[i] <= '0;
            end
        end else if (ctl.exec) begin
            if (clr_all) begin
                for (int i = 0; i < SCOPES; i++) begin
                    fc_reg[i] <= 8'd0;
                    dl_reg[i] <= '0;
                end
            end else if (wr_en) begin
                fc_reg[sidx] <= wr_fc;
                dl_reg[sidx] <= wr_dl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            item_reg <= s_data;
        end
        if (ctl.exec) begin
            granted_reg  <= granted_c;
            rejected_reg <= rejected_c;
            show_reg     <= is_op && scope_ok;
        end
    end

    // status cycle, reads the updated entry
    assign st_fc    = fc_reg[sidx];
    assign st_dl    = dl_reg[sidx];
    assign rem_diff = {1'b0, st_dl} - {1'b0, item_reg.now_ms};
    assign st_gt    = !rem_diff[TIME_W] && (rem_diff[TIME_W-1:0] != '0);
    assign st_rem   = !st_gt ? 32'd0 :
                      (rem_diff[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : rem_diff[31:0];
    assign att_diff = {1'b0, cfg.max_attempts} - {1'b0, st_fc};
    assign st_att   = att_diff[8] ? 8'd0 : att_diff[7:0];

    always_ff @(posedge aclk) begin
        if (ctl.publish) begin
            result_reg.granted       <= granted_reg;
            result_reg.rejected      <= rejected_reg;
            result_reg.locked        <= show_reg && st_gt;
            result_reg.remaining_ms  <= show_reg ? st_rem : 32'd0;
            result_reg.attempts_left <= show_reg ? st_att : 8'd0;
        end
    end

    assign m_data = result_reg;

endmodule

### design/pin_retry_lockout_controller_core.sv
// Top level of the PIN retry lockout controller: register bank, FSM and datapath.
// Depends on prlc_pkg, prlc_regs, prlc_ctrl, prlc_dp.
//
//   port group   dir   handshake          payload
//   s_*          in    s_valid/s_ready    s_data (in_t)
//   m_*          out   m_valid/m_ready    m_data (out_t)
//   apb          in    psel/penable       paddr, pwdata, prdata
//
// Each transaction passes through accept, execute (entry update, 48-bit compare
// and deadline add) and status (48-bit subtract into the output register).
// A new transaction is taken while a result waits in the output register; the
// status cycle stalls only when that register is still full.
// Reset is synchronous, active low, and clears all per-scope state at once.
module pin_retry_lockout_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  prlc_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output prlc_pkg::out_t                 m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prlc_pkg::PADDR_W-1:0]   paddr,
    input  logic [prlc_pkg::PDATA_W-1:0]   pwdata,
    output logic [prlc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import prlc_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t ctl;

    prlc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    prlc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cfg     (cfg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

### verif/pin_retry_lockout_controller_core_tb.sv
// Self-checking testbench for pin_retry_lockout_controller_core: drives commands over the
// valid/ready input channel, programs registers over APB and checks every result transaction.
// Depends on prlc_pkg and the controller RTL.
`timescale 1ns / 1ps

module pin_retry_lockout_controller_core_tb;
    import prlc_pkg::*;

    localparam logic [2:0] CMD_QUERY_REMAIN = 3'd2;
    localparam logic [2:0] CMD_UNUSED_LO    = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI    = 3'd7;
    localparam logic [1:0] BAD_SCOPE        = 2'(SCOPES);
    localparam logic [TIME_W-1:0] TIME_TOP  = '1;

    class lockout_scoreboard;
        cfg_t              cfg;
        logic [7:0]        fail_cnt [SCOPES];
        logic [TIME_W-1:0] deadline [SCOPES];
        out_t              status_q [$];
        int                failures;
        int                checked;
        int                grants;
        int                locks;
        int                rejects;

        function new();
            cfg.security_enabled = RST_SECURITY;
            cfg.max_attempts     = RST_MAX_ATTEMPTS;
            cfg.lockout_ms       = RST_LOCKOUT;
            foreach (fail_cnt[i]) clear_scope(i);
        endfunction

        function void clear_scope(int unsigned s);
            fail_cnt[s] = '0;
            deadline[s] = '0;
        endfunction

        function bit lock_active(int unsigned s, logic [TIME_W-1:0] now);
            return deadline[s] != '0 && now < deadline[s];
        endfunction

        function bit digits_ok(logic [15:0] pins);
            for (int i = 0; i < PIN_DIGITS; i++) begin
                if (pins[4*i +: 4] > DIGIT_MAX) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SECURITY:     cfg.security_enabled = value[0];
                REG_MAX_ATTEMPTS: cfg.max_attempts     = value[7:0];
                REG_LOCKOUT:      cfg.lockout_ms       = value;
                default: ;
            endcase
        endfunction

        function out_t predict_status(in_t t);
            out_t              r;
            bit                ok_scope;
            int unsigned       s;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] rem;
            r = '0;
            if (t.cmd > CMD_RESET_ALL) return r;
            ok_scope = t.scope < SCOPES;
            s = ok_scope ? t.scope : 0;
            if (t.cmd == CMD_RESET_ALL) begin
                foreach (fail_cnt[i]) clear_scope(i);
            end else if (!ok_scope) begin
                r.rejected = 1'b1;
            end
            if (t.cmd == CMD_VERIFY) begin
                if (!ok_scope || !digits_ok(t.pin_digits)) begin
                    r.rejected = 1'b1;
                end else if (!cfg.security_enabled && s == 0) begin
                    r.granted = 1'b1;
                end else if (!lock_active(s, t.now_ms)) begin
                    if (deadline[s] != '0) clear_scope(s);
                    if (t.hash_match) begin
                        clear_scope(s);
                        r.granted = 1'b1;
                    end else if (fail_cnt[s] != FAIL_MAX) begin
                        fail_cnt[s] = fail_cnt[s] + 8'd1;
                        if (fail_cnt[s] >= cfg.max_attempts) begin
                            sum = {1'b0, t.now_ms} + {17'd0, cfg.lockout_ms};
                            deadline[s] = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
                        end
                    end
                end
            end else if (t.cmd == CMD_QUERY_LOCK && ok_scope) begin
                if (!lock_active(s, t.now_ms) && deadline[s] != '0) clear_scope(s);
            end else if (t.cmd == CMD_RESET_SCOPE && ok_scope) begin
                clear_scope(s);
            end
            if (ok_scope) begin
                rem = (deadline[s] > t.now_ms) ? deadline[s] - t.now_ms : '0;
                r.remaining_ms  = (|rem[TIME_W-1:32]) ? 32'hFFFF_FFFF : rem[31:0];
                r.locked        = lock_active(s, t.now_ms);
                r.attempts_left = (fail_cnt[s] >= cfg.max_attempts) ? 8'd0
                                  : cfg.max_attempts - fail_cnt[s];
            end
            return r;
        endfunction

        function void note_input(in_t t);
            status_q.push_back(predict_status(t));
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (status_q.size() == 0) begin
                note_failure($sformatf("unexpected result g=%0d l=%0d rem=%0d left=%0d rej=%0d",
                    got.granted, got.locked, got.remaining_ms, got.attempts_left,
                    got.rejected));
                return;
            end
            exp = status_q.pop_front();
            if (got.granted !== exp.granted || got.locked !== exp.locked ||
                got.remaining_ms !== exp.remaining_ms ||
                got.attempts_left !== exp.attempts_left || got.rejected !== exp.rejected) begin
                note_failure($sformatf(
                    "txn %0d: exp g=%0d l=%0d rem=%0d left=%0d rej=%0d, got g=%0d l=%0d rem=%0d left=%0d rej=%0d",
                    checked, exp.granted, exp.locked, exp.remaining_ms, exp.attempts_left,
                    exp.rejected, got.granted, got.locked, got.remaining_ms,
                    got.attempts_left, got.rejected));
            end
            checked++;
            grants  += exp.granted;
            locks   += exp.locked;
            rejects += exp.rejected;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void close();
            if (status_q.size() != 0)
                note_failure($sformatf("%0d results never arrived", status_q.size()));
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    lockout_scoreboard    sb = new();
    logic [TIME_W-1:0]    cur_ms;
    int unsigned          burst_left;
    int unsigned          sent;
    int unsigned          settings;
    int unsigned          rx_mode;
    int unsigned          rx_left;
    int unsigned          rx_hold;
    logic                 rx_level;

    pin_retry_lockout_controller_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // result side: m_ready follows one of four randomly chosen stall patterns in turn
    initial begin
        m_ready  <= 1'b0;
        rx_left  = 0;
        rx_hold  = 0;
        rx_level = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (rx_hold == 0) begin
                        rx_hold  = $urandom_range(1, 12);
                        rx_level = ~rx_level;
                    end
                    rx_hold--;
                    m_ready <= rx_level;
                end
            endcase
        end
    end

    function automatic in_t pack_txn(logic [2:0] c, logic [1:0] sc, logic [TIME_W-1:0] t,
                                     logic [15:0] p, logic m);
        in_t x;
        x.cmd        = c;
        x.scope      = sc;
        x.now_ms     = t;
        x.pin_digits = p;
        x.hash_match = m;
        return x;
    endfunction

    function automatic logic [15:0] good_pins();
        logic [15:0] p;
        p = 16'($urandom);
        for (int i = 0; i < PIN_DIGITS; i++) p[4*i +: 4] = 4'($urandom_range(0, DIGIT_MAX));
        return p;
    endfunction

    task automatic send(in_t txn);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= txn;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(txn);
        if (txn.cmd <= CMD_RESET_ALL) sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic apply_setting(logic sec, logic [7:0] max_att, logic [31:0] lock_ms);
        drain();
        cfg_write(REG_SECURITY, {31'd0, sec});
        cfg_write(REG_MAX_ATTEMPTS, {24'd0, max_att});
        cfg_write(REG_LOCKOUT, lock_ms);
        settings++;
    endtask

    task automatic run_directed();
        send(pack_txn(CMD_VERIFY, 2'd0, 48'd1000, 16'h1234, 1'b1));
        send(pack_txn(CMD_VERIFY, BAD_SCOPE, 48'd1000, 16'h1234, 1'b1));
        send(pack_txn(CMD_VERIFY, 2'd1, 48'd1001, 16'h999A, 1'b1));
        send(pack_txn(CMD_VERIFY, 2'd2, 48'd1001, 16'hA999, 1'b0));
        send(pack_txn(CMD_VERIFY, 2'd2, 48'd1002, 16'h9990, 1'b0));
        // fifth miss arms the lockout at 2004 + 30000
        for (int i = 0; i < 5; i++)
            send(pack_txn(CMD_VERIFY, 2'd1, 48'd2000 + 48'(i), 16'h0000, 1'b0));
        send(pack_txn(CMD_VERIFY, 2'd1, 48'd2010, 16'h4321, 1'b1));
        send(pack_txn(CMD_QUERY_LOCK, 2'd1, 48'd2011, 16'hFFFF, 1'b0));
        send(pack_txn(CMD_QUERY_REMAIN, 2'd1, 48'd32003, 16'h0000, 1'b0));
        send(pack_txn(CMD_QUERY_LOCK, 2'd1, 48'd32004, 16'h0000, 1'b0));
        send(pack_txn(CMD_RESET_SCOPE, 2'd2, 48'd32005, 16'h0000, 1'b0));
        send(pack_txn(CMD_QUERY_REMAIN, BAD_SCOPE, 48'd32006, 16'h0000, 1'b0));
        send(pack_txn(CMD_RESET_SCOPE, BAD_SCOPE, 48'd32007, 16'h0000, 1'b0));
        send(pack_txn(CMD_VERIFY, 2'd0, TIME_TOP, 16'h9999, 1'b0));
        send(pack_txn(CMD_RESET_ALL, BAD_SCOPE, TIME_TOP, 16'hFFFF, 1'b1));
        send(pack_txn(CMD_UNUSED_LO, 2'd1, 48'd5, 16'h1111, 1'b1));
        send(pack_txn(CMD_UNUSED_HI, 2'd0, TIME_TOP, 16'hFFFF, 1'b1));
        send(pack_txn(CMD_VERIFY, 2'd0, 48'd0, 16'h0000, 1'b0));
        send(pack_txn(CMD_QUERY_LOCK, 2'd0, 48'd0, 16'h0000, 1'b0));
    endtask

    // misses at time zero with zero lockout never arm a lock, so the count saturates
    task automatic run_count_saturation(int unsigned n);
        logic [1:0] s;
        s = 2'($urandom_range(0, SCOPES - 1));
        for (int i = 0; i < n; i++) send(pack_txn(CMD_VERIFY, s, 48'd0, good_pins(), 1'b0));
        send(pack_txn(CMD_QUERY_REMAIN, s, 48'd0, 16'($urandom), 1'b0));
    endtask

    task automatic send_noise();
        logic [TIME_W-1:0] t;
        logic [63:0]       wide;
        wide = {$urandom, $urandom};
        t = $urandom_range(0, 1) ? wide[TIME_W-1:0] : cur_ms;
        send(pack_txn(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), t, 16'($urandom),
                      1'($urandom_range(0, 1))));
    endtask

    // misses up to and around the limit, probing while locked, then recovery
    task automatic run_lockout_cycle();
        logic [1:0]  s;
        int unsigned k;
        s = 2'($urandom_range(0, SCOPES - 1));
        case ($urandom_range(0, 9))
            0: cur_ms = '0;
            1: cur_ms = TIME_TOP - 48'($urandom_range(0, 2000));
            default: ;
        endcase
        k = sb.cfg.max_attempts + $urandom_range(0, 2);
        if (k > 1) k--;
        if (k > 12) k = $urandom_range(8, 12);
        for (int i = 0; i < k; i++) begin
            send(pack_txn(CMD_VERIFY, s, cur_ms, good_pins(), $urandom_range(0, 15) == 0));
            cur_ms += 48'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0)
                send(pack_txn($urandom_range(0, 1) ? CMD_QUERY_LOCK : CMD_QUERY_REMAIN, s,
                              cur_ms, 16'($urandom), 1'($urandom_range(0, 1))));
        end
        if (sb.deadline[s] != '0 && $urandom_range(0, 1))
            send(pack_txn(CMD_VERIFY, s, cur_ms, good_pins(), 1'b1));
        case ($urandom_range(0, 4))
            0, 1: begin
                if (sb.deadline[s] != '0) begin
                    cur_ms = sb.deadline[s] - 48'd1;
                    send(pack_txn(CMD_QUERY_REMAIN, s, cur_ms, 16'($urandom), 1'b0));
                    cur_ms += 48'($urandom_range(0, 2));
                end
                if ($urandom_range(0, 1))
                    send(pack_txn(CMD_VERIFY, s, cur_ms, good_pins(), 1'b1));
                else
                    send(pack_txn(CMD_QUERY_LOCK, s, cur_ms, 16'($urandom), 1'b0));
            end
            2: send(pack_txn(CMD_RESET_SCOPE, s, cur_ms, 16'($urandom), 1'b0));
            3: send(pack_txn(CMD_RESET_ALL, 2'($urandom_range(0, 3)), cur_ms, 16'($urandom),
                             1'($urandom_range(0, 1))));
            default: ;
        endcase
    endtask

    task automatic run_phase(int unsigned target);
        int unsigned stop;
        stop = sent + target;
        while (sent < stop) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            else run_lockout_cycle();
        end
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_data     <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cur_ms     = 48'd100;
        burst_left = 0;
        sent       = 0;
        settings   = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        apply_setting(1'b1, 8'd1, 32'd0);
        run_count_saturation(258);
        run_phase(100);
        apply_setting(1'b0, 8'd3, 32'd50);
        run_phase(225);
        apply_setting(1'b1, 8'd255, 32'hFFFF_FFFF);
        run_phase(225);
        apply_setting(1'b1, 8'd2, 32'd1000);
        run_phase(225);
        apply_setting(1'b0, 8'd7, 32'd30000);
        run_phase(225);

        drain();
        repeat (8) @(posedge aclk);
        sb.close();
        $display("Checked %0d result transactions under %0d register settings.",
                 sb.checked, settings);
        $display("Expected outcomes: %0d grants, %0d locked reports, %0d rejections; %0d errors.",
                 sb.grants, sb.locks, sb.rejects, sb.failures);
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
